@@ rtl/bpa_pkg.sv @@
// Package: shared constants, types and state codes of the buddy page allocator.
package bpa_pkg;

    localparam int unsigned FrameCountDefault    = 1024;
    localparam int unsigned TopBlockCountDefault = 128;
    localparam int unsigned FrameShift           = 12;
    localparam int unsigned MaxOrder             = 3;

    localparam logic [2:0] TagAlloc = 3'd4;
    localparam logic [2:0] TagCont  = 3'd5;
    localparam logic [2:0] TagOff   = 3'd6;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StBadOrder = 2'd1;
    localparam logic [1:0] StNoBlock  = 2'd2;
    localparam logic [1:0] StBadFree  = 2'd3;

    localparam logic KindAlloc = 1'b0;
    localparam logic KindFree  = 1'b1;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_A_SCAN,
        S_A_RD,
        S_A_UNL_P,
        S_A_UNL_N,
        S_A_SPLIT,
        S_A_SPLIT_P,
        S_A_DONE,
        S_F_RDHEAD,
        S_F_CHK,
        S_F_PUSH,
        S_F_PUSH_P,
        S_M_START,
        S_M_SCAN,
        S_M_SCAN_W,
        S_M_UNL_RD,
        S_M_UNL_P,
        S_M_UNL_N,
        S_M_TAG,
        S_M_PUSH,
        S_M_PUSH_P,
        S_RESP
    } t_state;

endpackage

@@ rtl/bpa_if.sv @@
// Interfaces: request and response channels of the buddy page allocator.
interface bpa_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  order;
    logic [63:0] address;
    modport source (output valid, kind, order, address, input ready);
    modport sink   (input valid, kind, order, address, output ready);
endinterface

interface bpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_address;
    logic [1:0]  status;
    modport source (output valid, block_address, status, input ready);
    modport sink   (input valid, block_address, status, output ready);
endinterface

@@ rtl/buddy_page_allocator_core.sv @@
// Top level: buddy page allocator, sequencer over tag and link memories.
//
// Usage: requests arrive on a valid/ready channel (kind, order, address);
// each request gives exactly one response beat (block_address, status).
// Requests are handled one at a time. The sequencer drives one write port
// and one read port on each memory (tags, next links, prev links). An
// allocate splits a larger block level by level when needed; a free checks
// the tags of the block, then tries merges over spans of up to 8 frames,
// first scanning each span and then unlinking and retagging its frames.
// The sequencer returns to idle after each request before the next one is
// accepted. After reset a clearing pass over all FRAME_COUNT frames writes
// the initial tags and order-3 chain; ready stays low meanwhile.
// The configuration register (base address) may be written at any time
// the block is idle, including during the pass. The response is held in
// an output register, so one more request can be taken while a beat is
// stalled; its result then waits in the sequencer with ready low until
// the pending beat is taken.
module buddy_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int unsigned FRAME_COUNT     = FrameCountDefault,
    parameter int unsigned TOP_BLOCK_COUNT = TopBlockCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    bpa_req_if.sink     req,
    bpa_rsp_if.source   rsp
);
    localparam int unsigned AW   = $clog2(FRAME_COUNT);
    localparam int unsigned LW   = AW + 1;
    localparam int unsigned TOPN = (TOP_BLOCK_COUNT < FRAME_COUNT / 8) ?
                                   TOP_BLOCK_COUNT : FRAME_COUNT / 8;
    localparam logic [LW-1:0] NIL      = LW'(FRAME_COUNT);
    localparam logic [LW-1:0] TOP_END  = LW'(TOPN * 8);

    t_state r_state, n_state;
    logic [63:0]   r_base;
    logic          r_kind;
    logic [2:0]    r_ord;
    logic [63:0]   r_addr;
    logic [LW-1:0] r_head [4];
    logic [LW-1:0] n_head [4];
    logic [LW-1:0] r_f, n_f;         // block frame
    logic [LW-1:0] r_i, n_i;         // scan frame / counter
    logic [LW-1:0] r_p, n_p, r_n, n_n;
    logic [2:0]    r_j, n_j;         // working order
    logic          r_bad, n_bad;
    logic [63:0]   r_waddr, n_waddr; // result being built
    logic [1:0]    r_wstat, n_wstat;
    logic          r_ovalid, n_ovalid;
    logic [63:0]   r_oaddr, n_oaddr;
    logic [1:0]    r_ostat, n_ostat;

    // memory ports
    logic          tag_we, nxt_we, prv_we;
    logic [AW-1:0] tag_wa, nxt_wa, prv_wa, tag_ra, nxt_ra, prv_ra;
    logic [2:0]    tag_wd, tag_rd;
    logic [LW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;

    bpa_ram #(.WIDTH(3), .DEPTH(FRAME_COUNT)) u_tag (
        .i_clk, .i_we(tag_we), .i_waddr(tag_wa), .i_wdata(tag_wd),
        .i_raddr(tag_ra), .o_rdata(tag_rd));
    bpa_ram #(.WIDTH(LW), .DEPTH(FRAME_COUNT)) u_nxt (
        .i_clk, .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(nxt_ra), .o_rdata(nxt_rd));
    bpa_ram #(.WIDTH(LW), .DEPTH(FRAME_COUNT)) u_prv (
        .i_clk, .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(prv_ra), .o_rdata(prv_rd));

    // free-address decode (one wide subtract)
    logic [63:0] off;
    logic [63:0] fr;
    logic [LW-1:0] span, send;
    assign off  = r_addr - r_base;
    assign fr   = off >> FrameShift;
    assign span = LW'(1) << r_ord[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_base   <= '0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            for (int k = 0; k < 4; k++) r_head[k] <= NIL;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_i      <= n_i;
            r_head   <= n_head;
            if (i_cfg_we) r_base <= i_cfg_wdata;
        end
        if (req.valid && req.ready) begin
            r_kind <= req.kind;
            r_ord  <= req.order;
            r_addr <= req.address;
        end
        r_f <= n_f; r_p <= n_p; r_n <= n_n; r_j <= n_j; r_bad <= n_bad;
        r_waddr <= n_waddr; r_wstat <= n_wstat;
        r_oaddr <= n_oaddr; r_ostat <= n_ostat;
    end

    assign req.ready         = (r_state == S_IDLE);
    assign rsp.valid         = r_ovalid;
    assign rsp.block_address = r_oaddr;
    assign rsp.status        = r_ostat;

    always_comb begin
        n_state = r_state; n_head = r_head;
        n_f = r_f; n_i = r_i; n_p = r_p; n_n = r_n; n_j = r_j; n_bad = r_bad;
        n_waddr = r_waddr; n_wstat = r_wstat;
        n_ovalid = r_ovalid; n_oaddr = r_oaddr; n_ostat = r_ostat;
        send = r_f + span;
        tag_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0;
        tag_wa = r_i[AW-1:0]; nxt_wa = r_i[AW-1:0]; prv_wa = r_i[AW-1:0];
        tag_wd = TagCont; nxt_wd = NIL; prv_wd = NIL;
        tag_ra = r_i[AW-1:0]; nxt_ra = r_f[AW-1:0]; prv_ra = r_f[AW-1:0];
        if (rsp.valid && rsp.ready) n_ovalid = 1'b0;
        case (r_state)
            S_INIT: begin
                // clearing pass: one frame per cycle
                tag_we = 1'b1; nxt_we = 1'b1; prv_we = 1'b1;
                if (r_i < TOP_END) begin
                    if (r_i[2:0] == 3'd0) begin
                        tag_wd = 3'(MaxOrder);
                        if (r_i + LW'(8) < TOP_END) nxt_wd = r_i + LW'(8);
                        if (r_i != '0) prv_wd = r_i - LW'(8);
                    end
                end else begin
                    tag_wd = TagOff;
                end
                if (r_i == NIL - LW'(1)) begin
                    n_i = '0;
                    n_state = S_IDLE;
                    n_head[3] = (TOPN > 0) ? '0 : NIL;
                end else begin
                    n_i = r_i + LW'(1);
                end
            end
            S_IDLE: begin
                if (req.valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_waddr = '0; n_wstat = StOk;
                if (r_ord > 3'(MaxOrder)) begin
                    n_wstat = StBadOrder; n_state = S_RESP;
                end else if (r_kind == KindAlloc) begin
                    n_j = r_ord; n_state = S_A_SCAN;
                end else if (off[FrameShift-1:0] != '0 ||
                             fr >= 64'(FRAME_COUNT) ||
                             (fr[LW-1:0] & (span - LW'(1))) != '0) begin
                    n_wstat = StBadFree; n_state = S_RESP;
                end else begin
                    n_f = fr[LW-1:0];
                    n_i = fr[LW-1:0];
                    n_bad = 1'b0;
                    n_state = S_F_RDHEAD;
                end
            end
            // ---------------- allocate ----------------
            S_A_SCAN: begin
                if (r_head[r_j[1:0]] < NIL) begin
                    n_f = r_head[r_j[1:0]];
                    n_state = S_A_RD;
                end else if (r_j == 3'(MaxOrder)) begin
                    n_wstat = StNoBlock; n_state = S_RESP;
                end else begin
                    n_j = r_j + 3'd1;
                end
            end
            S_A_RD: begin
                // address f on link reads; data ready next cycle
                n_state = S_A_UNL_P;
            end
            S_A_UNL_P: begin
                // f is the list head, so prev is nil
                n_n = nxt_rd;
                n_head[r_j[1:0]] = nxt_rd;
                nxt_we = 1'b1; nxt_wa = r_f[AW-1:0]; nxt_wd = NIL;
                n_state = S_A_UNL_N;
            end
            S_A_UNL_N: begin
                if (r_n < NIL) begin
                    prv_we = 1'b1; prv_wa = r_n[AW-1:0]; prv_wd = NIL;
                end
                n_state = S_A_SPLIT;
            end
            S_A_SPLIT: begin
                if (r_j == r_ord) begin
                    tag_we = 1'b1; tag_wa = r_f[AW-1:0]; tag_wd = TagAlloc;
                    n_state = S_A_DONE;
                end else begin
                    // push upper half of the level below
                    n_p = r_f + (LW'(1) << (r_j[1:0] - 2'd1));
                    n_j = r_j - 3'd1;
                    n_state = S_A_SPLIT_P;
                end
            end
            S_A_SPLIT_P: begin
                if (r_p < NIL) begin
                    tag_we = 1'b1; tag_wa = r_p[AW-1:0]; tag_wd = r_j;
                    nxt_we = 1'b1; nxt_wa = r_p[AW-1:0];
                    nxt_wd = r_head[r_j[1:0]];
                    prv_we = 1'b1; prv_wa = r_p[AW-1:0]; prv_wd = NIL;
                    n_head[r_j[1:0]] = r_p;
                    n_n = r_head[r_j[1:0]];
                    n_state = S_F_PUSH_P;  // fix old head's prev, then split
                    n_bad = 1'b1;          // marks return to split loop
                end else begin
                    n_state = S_A_SPLIT;
                end
            end
            S_A_DONE: begin
                n_waddr = r_base + (64'(r_f) << FrameShift);
                n_state = S_RESP;
            end
            // ---------------- free ----------------
            S_F_RDHEAD: begin
                // tag of f read issued (r_i = f)
                n_state = S_F_CHK;
                n_i = r_i + LW'(1);
                if (send > NIL) begin
                    n_wstat = StBadFree; n_state = S_RESP;
                end
            end
            S_F_CHK: begin
                // tag_rd holds tag of frame r_i-1
                if ((r_i - LW'(1) == r_f && tag_rd != TagAlloc) ||
                    (r_i - LW'(1) != r_f && tag_rd != TagCont)) begin
                    n_wstat = StBadFree; n_state = S_RESP;
                end else if (r_i == send) begin
                    n_state = S_F_PUSH;
                end else begin
                    n_i = r_i + LW'(1);
                end
            end
            S_F_PUSH: begin
                tag_we = 1'b1; tag_wa = r_f[AW-1:0]; tag_wd = r_ord;
                nxt_we = 1'b1; nxt_wa = r_f[AW-1:0];
                nxt_wd = r_head[r_ord[1:0]];
                prv_we = 1'b1; prv_wa = r_f[AW-1:0]; prv_wd = NIL;
                n_head[r_ord[1:0]] = r_f;
                n_n = r_head[r_ord[1:0]];
                n_p = r_f;
                n_j = r_ord + 3'd1;
                n_bad = 1'b0;
                n_state = S_F_PUSH_P;
            end
            S_F_PUSH_P: begin
                // shared: prev of the old head points to the new head
                if (r_n < NIL) begin
                    prv_we = 1'b1; prv_wa = r_n[AW-1:0]; prv_wd = r_p;
                end
                n_state = r_bad ? S_A_SPLIT : S_M_START;
            end
            // ---------------- merge ----------------
            S_M_START: begin
                if (r_j > 3'(MaxOrder)) begin
                    n_state = S_RESP;
                end else begin
                    n_f = r_f & ~((LW'(1) << r_j[1:0]) - LW'(1));
                    n_i = r_f & ~((LW'(1) << r_j[1:0]) - LW'(1));
                    n_state = S_M_SCAN;
                    if ((r_f & ~((LW'(1) << r_j[1:0]) - LW'(1)))
                        + (LW'(1) << r_j[1:0]) > NIL)
                        n_state = S_RESP;
                end
            end
            S_M_SCAN: begin
                // read tag r_i; check next cycle
                n_state = S_M_SCAN_W;
            end
            S_M_SCAN_W: begin
                if (tag_rd == TagAlloc || tag_rd == TagOff) begin
                    n_state = S_RESP;
                end else if (r_i + LW'(1) ==
                             r_f + (LW'(1) << r_j[1:0])) begin
                    n_i = r_f;
                    n_state = S_M_UNL_RD;
                end else begin
                    n_i = r_i + LW'(1);
                    n_state = S_M_SCAN;
                end
            end
            S_M_UNL_RD: begin
                // read tag and links of r_i
                tag_ra = r_i[AW-1:0];
                nxt_ra = r_i[AW-1:0]; prv_ra = r_i[AW-1:0];
                n_state = S_M_UNL_P;
            end
            S_M_UNL_P: begin
                nxt_ra = r_i[AW-1:0]; prv_ra = r_i[AW-1:0];
                if (tag_rd <= 3'(MaxOrder)) begin
                    n_p = prv_rd; n_n = nxt_rd;
                    if (prv_rd < NIL) begin
                        nxt_we = 1'b1; nxt_wa = prv_rd[AW-1:0];
                        nxt_wd = nxt_rd;
                    end else if (r_head[tag_rd[1:0]] == r_i) begin
                        n_head[tag_rd[1:0]] = nxt_rd;
                    end
                    n_state = S_M_UNL_N;
                end else begin
                    n_state = S_M_TAG;
                end
            end
            S_M_UNL_N: begin
                if (r_n < NIL) begin
                    prv_we = 1'b1; prv_wa = r_n[AW-1:0]; prv_wd = r_p;
                end
                n_state = S_M_TAG;
            end
            S_M_TAG: begin
                tag_we = 1'b1; tag_wa = r_i[AW-1:0]; tag_wd = TagCont;
                // clear links of the unlinked frame
                nxt_we = 1'b1; nxt_wa = r_i[AW-1:0]; nxt_wd = NIL;
                prv_we = 1'b1; prv_wa = r_i[AW-1:0]; prv_wd = NIL;
                if (r_i + LW'(1) == r_f + (LW'(1) << r_j[1:0])) begin
                    n_state = S_M_PUSH;
                end else begin
                    n_i = r_i + LW'(1);
                    n_state = S_M_UNL_RD;
                end
            end
            S_M_PUSH: begin
                tag_we = 1'b1; tag_wa = r_f[AW-1:0]; tag_wd = r_j;
                nxt_we = 1'b1; nxt_wa = r_f[AW-1:0];
                nxt_wd = r_head[r_j[1:0]];
                prv_we = 1'b1; prv_wa = r_f[AW-1:0]; prv_wd = NIL;
                n_head[r_j[1:0]] = r_f;
                n_n = r_head[r_j[1:0]];
                n_p = r_f;
                n_state = S_M_PUSH_P;
            end
            S_M_PUSH_P: begin
                if (r_n < NIL) begin
                    prv_we = 1'b1; prv_wa = r_n[AW-1:0]; prv_wd = r_p;
                end
                n_j = r_j + 3'd1;
                n_state = S_M_START;
            end
            S_RESP: begin
                // move the result into the output register once it is free
                if (!r_ovalid || rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_oaddr = r_waddr;
                    n_ostat = r_wstat;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // scan states read the tag at r_i
        if (r_state == S_F_RDHEAD || r_state == S_F_CHK ||
            r_state == S_M_SCAN) tag_ra = r_i[AW-1:0];
    end

    // ready is never high while a result waits in S_RESP
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.ready |-> !(r_state == S_RESP))
        else $error("ready while response pending");
    // a request is followed by the sequencer leaving idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req.valid && req.ready) |=> (r_state == S_CHECK))
        else $error("request not taken");
    // a stalled response beat holds its status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && !rsp.ready) |=> $stable(rsp.status))
        else $error("response changed under stall");
endmodule

@@ rtl/bpa_ram.sv @@
// Generic single-port-write, one-port-read RAM with registered read data.
module bpa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ test/tb_bpa_checker.sv @@
`timescale 1ns / 1ps
// Checker: watches request and response beats, predicts results and compares.
module tb_bpa_checker
    import bpa_pkg::*;
#(
    parameter int unsigned FRAME_COUNT     = FrameCountDefault,
    parameter int unsigned TOP_BLOCK_COUNT = TopBlockCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    bpa_req_if          req,
    bpa_rsp_if          rsp,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned NIL = FRAME_COUNT;

    typedef struct packed {
        logic [63:0] block_address;
        logic [1:0]  status;
    } t_grant;

    logic [63:0] base_addr;
    logic [2:0]  tag_mem  [FRAME_COUNT];
    int unsigned nxt_mem  [FRAME_COUNT];
    int unsigned prv_mem  [FRAME_COUNT];
    int unsigned head_mem [4];
    t_grant      grant_q  [$];

    assign o_pending = grant_q.size();

    function automatic void pool_reset();
        int unsigned top;
        top = FRAME_COUNT / 8;
        if (TOP_BLOCK_COUNT < top) top = TOP_BLOCK_COUNT;
        for (int unsigned i = 0; i < FRAME_COUNT; i++) begin
            nxt_mem[i] = NIL;
            prv_mem[i] = NIL;
            if (i < top * 8) tag_mem[i] = (i % 8 == 0) ? 3'(MaxOrder) : TagCont;
            else tag_mem[i] = TagOff;
        end
        for (int unsigned i = 0; i < top; i++) begin
            if (i + 1 < top) nxt_mem[i * 8] = (i + 1) * 8;
            if (i > 0) prv_mem[i * 8] = (i - 1) * 8;
        end
        head_mem[0] = NIL;
        head_mem[1] = NIL;
        head_mem[2] = NIL;
        head_mem[3] = (top > 0) ? 0 : NIL;
    endfunction

    function automatic void list_push(int unsigned ord, int unsigned f);
        int unsigned h;
        h = head_mem[ord];
        prv_mem[f] = NIL;
        nxt_mem[f] = h;
        if (h < NIL) prv_mem[h] = f;
        head_mem[ord] = f;
    endfunction

    function automatic void list_unlink(int unsigned ord, int unsigned f);
        int unsigned p, n;
        p = prv_mem[f];
        n = nxt_mem[f];
        if (p < NIL) nxt_mem[p] = n;
        else if (head_mem[ord] == f) head_mem[ord] = n;
        if (n < NIL) prv_mem[n] = p;
        prv_mem[f] = NIL;
        nxt_mem[f] = NIL;
    endfunction

    function automatic void coalesce(int unsigned f, int unsigned ord);
        int unsigned span, start;
        while (ord <= MaxOrder) begin
            span  = 1 << ord;
            start = f & ~(span - 1);
            if (start + span > FRAME_COUNT) return;
            for (int unsigned i = start; i < start + span; i++)
                if (tag_mem[i] == TagAlloc || tag_mem[i] == TagOff) return;
            for (int unsigned i = start; i < start + span; i++) begin
                if (tag_mem[i] <= MaxOrder) list_unlink(32'(tag_mem[i]), i);
                tag_mem[i] = TagCont;
            end
            tag_mem[start] = 3'(ord);
            list_push(ord, start);
            ord++;
        end
    endfunction

    function automatic t_grant serve(logic kind, logic [2:0] ord_in, logic [63:0] addr);
        t_grant      g;
        int unsigned ord, j, f, span;
        logic [63:0] off, fr;
        g = '0;
        ord = 32'(ord_in);
        if (ord > MaxOrder) begin
            g.status = StBadOrder;
            return g;
        end
        if (kind == KindAlloc) begin
            j = ord;
            while (j <= MaxOrder && head_mem[j] >= NIL) j++;
            if (j > MaxOrder) begin
                g.status = StNoBlock;
                return g;
            end
            f = head_mem[j];
            list_unlink(j, f);
            for (int unsigned l = j; l > ord; l--) begin
                tag_mem[f + (1 << (l - 1))] = 3'(l - 1);
                list_push(l - 1, f + (1 << (l - 1)));
            end
            tag_mem[f] = TagAlloc;
            g.block_address = base_addr + (64'(f) << FrameShift);
            return g;
        end
        off  = addr - base_addr;
        fr   = off >> FrameShift;
        span = 1 << ord;
        g.status = StBadFree;
        if (off[11:0] != 0 || fr >= 64'(FRAME_COUNT) || (fr & 64'(span - 1)) != 0)
            return g;
        f = fr[31:0];
        if (tag_mem[f] != TagAlloc || f + span > FRAME_COUNT) return g;
        for (int unsigned i = f + 1; i < f + span; i++)
            if (tag_mem[i] != TagCont) return g;
        tag_mem[f] = 3'(ord);
        list_push(ord, f);
        coalesce(f, ord + 1);
        g.status = StOk;
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            pool_reset();
            base_addr    = '0;
            o_fail_count = 0;
            grant_q.delete();
        end else begin
            if (i_cfg_we) base_addr = i_cfg_wdata;
            if (req.valid && req.ready)
                grant_q.push_back(serve(req.kind, req.order, req.address));
            if (rsp.valid && rsp.ready) begin
                if (grant_q.size() == 0) begin
                    $error("response beat with nothing expected");
                    o_fail_count++;
                end else begin
                    want = grant_q[0];
                    grant_q.delete(0);
                    if (rsp.block_address !== want.block_address) begin
                        $error("block_address expected %h actual %h",
                               want.block_address, rsp.block_address);
                        o_fail_count++;
                    end
                    if (rsp.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, rsp.status);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ test/tb_buddy_page_allocator_core.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the buddy page allocator.
module tb_buddy_page_allocator_core
    import bpa_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [63:0] i_cfg_wdata;
    int          fail_count;
    int          pending;

    bpa_req_if req ();
    bpa_rsp_if rsp ();

    // Addresses handed out and not yet freed, as seen on the response side.
    logic [63:0] live_blk [$];
    logic [1:0]  live_ord [$];
    logic [1:0]  sent_ord [$];   // orders of accepted request beats, in flight
    logic        sent_alloc [$];
    logic [63:0] base_now;
    bit          hold_off;

    buddy_page_allocator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .req         (req.sink),
        .rsp         (rsp.source)
    );

    tb_bpa_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .req          (req),
        .rsp          (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 4) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Receiver: random stalls, plus one long hold-off while requests keep coming.
    always @(posedge i_clk) begin
        if (!i_rst_n) rsp.ready <= 1'b0;
        else if (hold_off) rsp.ready <= 1'b0;
        else rsp.ready <= (gap_len() == 0);
    end

    // Track live blocks from response beats so frees mostly hit real blocks.
    always @(posedge i_clk) begin
        if (i_rst_n && req.valid && req.ready) begin
            sent_alloc.push_back(req.kind == KindAlloc && req.order <= MaxOrder);
            sent_ord.push_back(req.order[1:0]);
        end
        if (i_rst_n && rsp.valid && rsp.ready && sent_alloc.size() > 0) begin
            if (sent_alloc[0] && rsp.status == StOk) begin
                live_blk.push_back(rsp.block_address);
                live_ord.push_back(sent_ord[0]);
            end
            sent_alloc.delete(0);
            sent_ord.delete(0);
        end
    end

    task automatic send_beat(logic kind, logic [2:0] ord, logic [63:0] addr);
        int g;
        g = gap_len();
        if (g > 0) begin
            req.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req.valid   <= 1'b1;
        req.kind    <= kind;
        req.order   <= ord;
        req.address <= addr;
        do @(posedge i_clk); while (!req.ready);
    endtask

    task automatic settle();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || sent_alloc.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_base(logic [63:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        base_now     = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Free a random live block: sometimes with a wrong order or a skewed address.
    task automatic free_live(bit clean);
        int k;
        logic [63:0] a;
        logic [2:0]  o;
        k = $urandom_range(0, live_blk.size() - 1);
        a = live_blk[k];
        o = {1'b0, live_ord[k]};
        if (clean || $urandom_range(0, 3) != 0) begin
            live_blk.delete(k);
            live_ord.delete(k);
        end
        if (!clean) begin
            case ($urandom_range(0, 3))
                0: a = a + 64'($urandom_range(1, 4095));
                1: o = 3'($urandom_range(0, 7));
                default: ;
            endcase
        end
        send_beat(KindFree, o, a);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: send_beat(1'($urandom_range(0, 1)), 3'($urandom_range(4, 7)),
                             {$urandom, $urandom});
                1: send_beat(KindFree, 3'($urandom_range(0, 3)), {$urandom, $urandom});
                2: send_beat(KindFree, 3'($urandom_range(0, 3)),
                             base_now + (64'($urandom_range(0, 1100)) << FrameShift));
                3, 4, 5, 6, 7, 8, 9:
                    if (live_blk.size() > 0) free_live(1'b0);
                    else send_beat(KindAlloc, 3'($urandom_range(0, 3)),
                                   {$urandom, $urandom});
                default: send_beat(KindAlloc, 3'($urandom_range(0, 3)),
                                   {$urandom, $urandom});
            endcase
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        req.valid   = 1'b0;
        req.kind    = KindAlloc;
        req.order   = '0;
        req.address = '0;
        hold_off    = 1'b0;
        base_now    = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every order, bad orders, bad frees, then free everything back.
        for (int o = 0; o < 8; o++) send_beat(KindAlloc, 3'(o), '0);
        send_beat(KindFree, 3'd7, '1);
        send_beat(KindFree, 3'd0, 64'h123);                  // unaligned
        send_beat(KindFree, 3'd0, 64'd1024 << FrameShift);   // past the region
        send_beat(KindFree, 3'd1, 64'h1000);                 // misaligned for order
        send_beat(KindFree, 3'd0, 64'h7000);                 // continuation frame inside an allocated block
        settle();
        send_beat(KindFree, 3'd2, live_blk[0]);              // wrong order on a live block
        while (live_blk.size() > 0) begin
            free_live(1'b1);
            settle();
        end

        // Exhaust the pool with order-3 allocations and overflow once.
        write_base(64'hFFFF_FFFF_FFFF_F000);
        for (int i = 0; i < 129; i++) send_beat(KindAlloc, 3'd3, '0);
        send_beat(KindAlloc, 3'd0, '0);
        settle();
        while (live_blk.size() > 0) free_live(1'b1);
        settle();

        // Random phases under several bases; long receiver hold-off in the first.
        write_base({$urandom, 20'h0, 12'h000});
        fork
            begin
                repeat (5) @(posedge i_clk);
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(60);
        join
        settle();
        write_base(64'h0);
        random_phase(60);
        settle();
        write_base(64'hAAAA_5555_0000_0000);
        random_phase(60);
        settle();

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator_core.sv
test/tb_bpa_checker.sv
test/tb_buddy_page_allocator_core.sv
